[design/sha1_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the SHA-1 hash engine.
package sha1_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int DIGEST_WORDS = 5;
  localparam int IDX_W        = 3;
  localparam int ROUND_W      = 7;

  localparam logic [ROUND_W-1:0] ROUND_LAST = 7'd79;
  localparam logic [ROUND_W-1:0] ROUND_F2   = 7'd20;
  localparam logic [ROUND_W-1:0] ROUND_F3   = 7'd40;
  localparam logic [ROUND_W-1:0] ROUND_F4   = 7'd60;

  localparam logic [4:0][31:0] H_INIT = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [31:0] K_R0 = 32'h5A827999;
  localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_R3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK     = 8'h80;
  localparam logic [5:0] LEN_POS      = 6'd56;
  localparam logic [5:0] BLOCK_LAST   = 6'd63;
  localparam logic [63:0] BITS_PER_BYTE = 64'd8;

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_BYTE_END,
    KIND_END
  } item_kind_t;

  typedef struct packed {
    item_kind_t kind;
    logic [7:0] data;
  } queue_entry_t;

endpackage

[design/sha1_front.sv]
`timescale 1ns / 1ps
// Input front end: classifies incoming transactions and pushes them to the queue.
module sha1_front (
  input  logic                  in_valid,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_byte_valid,
  input  logic                  in_end_of_message,
  output logic                  in_stall,
  input  logic                  q_full,
  output logic                  q_push,
  output sha1_pkg::queue_entry_t q_push_entry
);
  import sha1_pkg::*;

  item_kind_t kind;
  logic       useful;

  always_comb begin
    kind   = KIND_BYTE;
    useful = 1'b1;
    unique case ({in_byte_valid, in_end_of_message})
      2'b10: kind = KIND_BYTE;
      2'b11: kind = KIND_BYTE_END;
      2'b01: kind = KIND_END;
      default: useful = 1'b0;
    endcase
  end

  assign in_stall          = q_full;
  assign q_push            = in_valid && !q_full && useful;
  assign q_push_entry.kind = kind;
  assign q_push_entry.data = in_data_byte;

endmodule

[design/sha1_queue.sv]
`timescale 1ns / 1ps
// Short FIFO between the front end and the hash core.
module sha1_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  sha1_pkg::queue_entry_t push_entry,
  input  logic                   pop,
  output logic                   full,
  output logic                   valid,
  output sha1_pkg::queue_entry_t pop_entry
);
  import sha1_pkg::*;

  queue_entry_t            entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]       count_r, count_nxt;
  logic                    do_push, do_pop;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign valid     = (count_r != '0);
  assign pop_entry = entries_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

[design/sha1_core.sv]
`timescale 1ns / 1ps
// Hash core: byte packing, padding, 80-round compression and digest output.
module sha1_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  sha1_pkg::queue_entry_t q_entry,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [31:0]            out_digest_word,
  output logic [2:0]             out_word_index,
  output logic                   out_last_word
);
  import sha1_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    PH_NONE,
    PH_MARK,
    PH_FILL,
    PH_LEN,
    PH_DONE
  } phase_t;

  state_t              state_r, state_nxt;
  phase_t              phase_r, phase_nxt;
  logic [5:0]          pos_r, pos_nxt;
  logic [63:0]         bit_count_r, bit_count_nxt;
  logic [15:0][31:0]   block_r, block_nxt;
  logic [4:0][31:0]    work_r, work_nxt;
  logic [4:0][31:0]    hash_r, hash_nxt;
  logic [ROUND_W-1:0]  round_r, round_nxt;
  logic [2:0]          len_idx_r, len_idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [31:0]         out_word_r, out_word_nxt;
  logic [IDX_W-1:0]    out_idx_r, out_idx_nxt;
  logic                out_last_r, out_last_nxt;

  logic                do_absorb;
  logic [7:0]          abs_byte;
  logic [63:0]         len_sh;
  logic [31:0]         a, b, c, d, e, f, k, tmp, w_new;
  logic [IDX_W-1:0]    idx_inc;

  assign a = work_r[0];
  assign b = work_r[1];
  assign c = work_r[2];
  assign d = work_r[3];
  assign e = work_r[4];

  assign len_sh  = bit_count_r << {len_idx_r, 3'b000};
  assign idx_inc = out_idx_r + 1'b1;

  always_comb begin
    if (round_r < ROUND_F2) begin
      f = (b & c) | (~b & d);
      k = K_R0;
    end else if (round_r < ROUND_F3) begin
      f = b ^ c ^ d;
      k = K_R1;
    end else if (round_r < ROUND_F4) begin
      f = (b & c) | (b & d) | (c & d);
      k = K_R2;
    end else begin
      f = b ^ c ^ d;
      k = K_R3;
    end
  end

  assign tmp   = {a[26:0], a[31:27]} + f + e + k + block_r[15];
  assign w_new = block_r[2] ^ block_r[7] ^ block_r[13] ^ block_r[15];

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    bit_count_nxt = bit_count_r;
    block_nxt     = block_r;
    work_nxt      = work_r;
    hash_nxt      = hash_r;
    round_nxt     = round_r;
    len_idx_nxt   = len_idx_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    do_absorb     = 1'b0;
    abs_byte      = 8'h00;
    q_pop         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_entry.kind)
            KIND_BYTE: begin
              do_absorb     = 1'b1;
              abs_byte      = q_entry.data;
              bit_count_nxt = bit_count_r + BITS_PER_BYTE;
            end
            KIND_BYTE_END: begin
              do_absorb     = 1'b1;
              abs_byte      = q_entry.data;
              bit_count_nxt = bit_count_r + BITS_PER_BYTE;
              phase_nxt     = PH_MARK;
              state_nxt     = ST_PAD;
            end
            KIND_END: begin
              phase_nxt = PH_MARK;
              state_nxt = ST_PAD;
            end
            default: ;
          endcase
        end
      end
      ST_PAD: begin
        unique case (phase_r)
          PH_MARK: begin
            do_absorb = 1'b1;
            abs_byte  = PAD_MARK;
            phase_nxt = PH_FILL;
          end
          PH_FILL: begin
            if (pos_r != LEN_POS) begin
              do_absorb = 1'b1;
            end else begin
              phase_nxt   = PH_LEN;
              len_idx_nxt = '0;
            end
          end
          PH_LEN: begin
            do_absorb   = 1'b1;
            abs_byte    = len_sh[63:56];
            len_idx_nxt = len_idx_r + 1'b1;
            if (len_idx_r == 3'd7) begin
              phase_nxt = PH_DONE;
            end
          end
          default: ;
        endcase
      end
      ST_ROUND: begin
        work_nxt  = {d, c, {b[1:0], b[31:2]}, a, tmp};
        block_nxt = {block_r[14:0], {w_new[30:0], w_new[31]}};
        round_nxt = round_r + 1'b1;
        if (round_r == ROUND_LAST) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        for (int i = 0; i < DIGEST_WORDS; i++) begin
          hash_nxt[i] = hash_r[i] + work_r[i];
        end
        if (phase_r == PH_NONE) begin
          state_nxt = ST_IDLE;
        end else if (phase_r == PH_DONE) begin
          state_nxt     = ST_EMIT;
          out_valid_nxt = 1'b1;
          out_word_nxt  = hash_nxt[0];
          out_idx_nxt   = '0;
          out_last_nxt  = 1'b0;
        end else begin
          state_nxt = ST_PAD;
        end
      end
      ST_EMIT: begin
        if (out_valid_r && !out_stall) begin
          if (out_last_r) begin
            out_valid_nxt = 1'b0;
            hash_nxt      = H_INIT;
            pos_nxt       = '0;
            bit_count_nxt = '0;
            phase_nxt     = PH_NONE;
            state_nxt     = ST_IDLE;
          end else begin
            out_idx_nxt  = idx_inc;
            out_word_nxt = hash_r[idx_inc];
            out_last_nxt = (idx_inc == IDX_W'(DIGEST_WORDS - 1));
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (do_absorb) begin
      block_nxt = {block_r[15][23:0], block_r[14:0], abs_byte};
      pos_nxt   = pos_r + 1'b1;
      if (pos_r == BLOCK_LAST) begin
        state_nxt = ST_ROUND;
        work_nxt  = hash_r;
        round_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_NONE;
      pos_r       <= '0;
      bit_count_r <= '0;
      hash_r      <= H_INIT;
      round_r     <= '0;
      len_idx_r   <= '0;
      out_valid_r <= 1'b0;
      out_idx_r   <= '0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      bit_count_r <= bit_count_nxt;
      hash_r      <= hash_nxt;
      round_r     <= round_nxt;
      len_idx_r   <= len_idx_nxt;
      out_valid_r <= out_valid_nxt;
      out_idx_r   <= out_idx_nxt;
      out_last_r  <= out_last_nxt;
    end
    block_r    <= block_nxt;
    work_r     <= work_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_word_index  = out_idx_r;
  assign out_last_word   = out_last_r;

endmodule

[design/sha1_hash_engine_top.sv]
`timescale 1ns / 1ps
// SHA-1 hash engine top level: front end, transaction queue and hash core.
//
//   channel   handshake           payload
//   in_       in_valid/in_stall   in_data_byte, in_byte_valid, in_end_of_message
//   out_      out_valid/out_stall out_digest_word, out_word_index, out_last_word
//
// A byte transaction is absorbed while the core is idle; every 64th byte starts
// a compression and fold, in which no bytes are taken. Closing a message pads one
// byte per cycle, pausing while a full block compresses, then compresses, then
// shows five digest words, one per accepted transaction; out_stall holds the
// word in place. Synchronous active-low reset loads the initial chaining values.
module sha1_hash_engine_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sha1_pkg::*;

  logic         q_full;
  logic         q_push;
  logic         q_pop;
  logic         q_valid;
  queue_entry_t q_push_entry;
  queue_entry_t q_pop_entry;

  sha1_front u_front (
    .in_valid          (in_valid),
    .in_data_byte      (in_data_byte),
    .in_byte_valid     (in_byte_valid),
    .in_end_of_message (in_end_of_message),
    .in_stall          (in_stall),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_push_entry      (q_push_entry)
  );

  sha1_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .pop        (q_pop),
    .full       (q_full),
    .valid      (q_valid),
    .pop_entry  (q_pop_entry)
  );

  sha1_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_entry         (q_pop_entry),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

endmodule
